// ===== src/twsm_pkg.sv =====
package twsm_pkg;

  localparam int VECTOR_BINS_DEF = 64;
  localparam int TOP_COUNT_DEF   = 8;
  localparam int USED_BINS       = 48;
  localparam int MASK_BINS       = 64;
  localparam int UW              = $clog2(USED_BINS);
  localparam int QUEUE_DEPTH     = 2;

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [MASK_BINS-1:0] PILOT_MASK = (64'd1 << 8) | (64'd1 << 16) | (64'd1 << 20)
    | (64'd1 << 28) | (64'd1 << 36) | (64'd1 << 44) | (64'd1 << 48) | (64'd1 << 56);

  localparam logic [5:0] USED_POS [USED_BINS] = '{
    6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd12, 6'd13, 6'd14,
    6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
    6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd40, 6'd41,
    6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd51, 6'd52, 6'd54, 6'd55, 6'd56, 6'd57, 6'd58
  };

  typedef enum logic {
    OP_TAP    = 1'b0,
    OP_SAMPLE = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_COMMIT
  } back_state_t;

  typedef struct packed {
    logic               mode;
    logic [5:0]         tap_position;
    logic signed [15:0] tap_weight;
    logic signed [15:0] primary_re;
    logic signed [15:0] primary_im;
    logic signed [15:0] alternate_re;
    logic signed [15:0] alternate_im;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               from_alternate;
    logic [5:0]         bin_number;
    logic               vector_end;
  } out_item_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [UW-1:0]      used_idx;
    logic signed [7:0]  weight;
    logic signed [15:0] primary_re;
    logic signed [15:0] primary_im;
    logic signed [15:0] alternate_re;
    logic signed [15:0] alternate_im;
  } op_t;

  typedef struct packed {
    logic          hit;
    logic [UW-1:0] idx;
  } tap_hit_t;

  function automatic logic [MASK_BINS-1:0] used_mask_f();
    logic [MASK_BINS-1:0] m;
    m = '0;
    for (int i = 0; i < USED_BINS; i++) begin
      m[USED_POS[i]] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [MASK_BINS-1:0] USED_MASK = used_mask_f();

  function automatic tap_hit_t pos_lookup(input logic [5:0] pos);
    tap_hit_t r;
    r = '0;
    for (int i = 0; i < USED_BINS; i++) begin
      if (USED_POS[i] == pos) begin
        r.hit = 1'b1;
        r.idx = UW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic signed [7:0] reset_weight(input logic [UW-1:0] idx);
    logic signed [7:0] w;
    w = PILOT_MASK[USED_POS[idx]] ? 8'sd2 : 8'sd1;
    return w;
  endfunction

  function automatic logic signed [7:0] round_q88(input logic signed [15:0] w);
    logic [16:0] mag;
    logic [16:0] sum;
    logic [8:0]  r;
    logic [7:0]  res;
    mag = w[15] ? (17'd0 - {w[15], w}) : {1'b0, w};
    sum = mag + 17'd128;
    r   = sum[16:8];
    if (w[15]) begin
      res = 8'd0 - r[7:0];
    end else if (r > 9'd127) begin
      res = 8'd127;
    end else begin
      res = r[7:0];
    end
    return res;
  endfunction

endpackage

// ===== src/top_weight_subcarrier_mux.sv =====
// channel   ports                               moves
// ------    ---------------------------------   --------------------------------------
// input     in_valid / in_ready / in_item        tap write (mode 0) or sample pair
// result    out_valid / out_ready / out_item     selected sample, bin, end of vector
//
// Sample items pass at one per cycle through the queue and the output register unless
// the result side stalls. A tap write starts a rank walk: TOP_COUNT passes over the
// weight memory (scan of all USED_BINS entries, drain, commit); samples behind it wait.
// Reset runs the same walk on the reset weights before the first sample is served.
// While the result side stalls, the input side accepts items until the queue is full.
module top_weight_subcarrier_mux #(
  parameter int VECTOR_BINS = twsm_pkg::VECTOR_BINS_DEF,
  parameter int TOP_COUNT   = twsm_pkg::TOP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  twsm_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output twsm_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);

  twsm_pkg::op_t push_data;
  logic          push_valid;
  logic          push_ready;
  twsm_pkg::op_t q_data;
  logic          q_valid;
  logic          q_pop;

  twsm_front u_front (
    .in_item    (in_item),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  twsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  twsm_back #(
    .VECTOR_BINS (VECTOR_BINS),
    .TOP_COUNT   (TOP_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// ===== src/twsm_front.sv =====
module twsm_front (
  input  twsm_pkg::in_item_t in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output twsm_pkg::op_t      push_data,
  output logic               push_valid,
  input  logic               push_ready
);

  twsm_pkg::tap_hit_t hit;

  assign hit      = twsm_pkg::pos_lookup(in_item.tap_position);
  assign in_ready = push_ready;

  always_comb begin
    push_data.kind         = (in_item.mode == twsm_pkg::MODE_SAMPLE) ?
                             twsm_pkg::OP_SAMPLE : twsm_pkg::OP_TAP;
    push_data.used_idx     = hit.idx;
    push_data.weight       = twsm_pkg::round_q88(in_item.tap_weight);
    push_data.primary_re   = in_item.primary_re;
    push_data.primary_im   = in_item.primary_im;
    push_data.alternate_re = in_item.alternate_re;
    push_data.alternate_im = in_item.alternate_im;
    // drop writes to unused bins
    push_valid = in_valid && ((in_item.mode == twsm_pkg::MODE_SAMPLE) || hit.hit);
  end

endmodule

// ===== src/twsm_queue.sv =====
module twsm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  twsm_pkg::op_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output twsm_pkg::op_t pop_data,
  output logic          pop_valid,
  input  logic          pop
);

  localparam int DEPTH = twsm_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  twsm_pkg::op_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/twsm_back.sv =====
module twsm_back #(
  parameter int VECTOR_BINS = twsm_pkg::VECTOR_BINS_DEF,
  parameter int TOP_COUNT   = twsm_pkg::TOP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  twsm_pkg::op_t       q_data,
  input  logic                q_valid,
  output logic                q_pop,
  output twsm_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int BW   = (VECTOR_BINS > 1) ? $clog2(VECTOR_BINS) : 1;
  localparam int PW   = $clog2(TOP_COUNT + 1);
  localparam int UW   = twsm_pkg::UW;
  localparam int USED = twsm_pkg::USED_BINS;
  localparam int MB   = twsm_pkg::MASK_BINS;

  twsm_pkg::back_state_t state_r, state_nxt;

  logic signed [7:0]   weight_mem [USED];
  logic signed [7:0]   rd_data_r;
  logic [USED-1:0]     wvalid_r, wvalid_nxt;
  logic                rd_wvalid_r;
  logic                rd_vld_r, rd_vld_nxt;
  logic [UW-1:0]       rd_idx_r;
  logic [UW-1:0]       scan_addr_r, scan_addr_nxt;
  logic [PW-1:0]       pass_r, pass_nxt;
  logic [MB-1:0]       mask_r, mask_nxt;
  logic                have_best_r, have_best_nxt;
  logic signed [7:0]   best_w_r, best_w_nxt;
  logic [UW-1:0]       best_idx_r, best_idx_nxt;
  logic [BW-1:0]       bin_r, bin_nxt;
  logic                out_valid_r, out_valid_nxt;
  twsm_pkg::out_item_t out_item_r, out_item_nxt;

  logic                out_free;
  logic                pop_tap;
  logic                pop_smp;
  logic signed [7:0]   cur_w;
  logic                cand;
  logic [BW+5:0]       bin_ext;
  logic                alt;
  logic                last_bin;

  assign out_free = !out_valid_r || out_ready;
  assign pop_tap  = (state_r == twsm_pkg::BK_IDLE) && q_valid &&
                    (q_data.kind == twsm_pkg::OP_TAP);
  assign pop_smp  = (state_r == twsm_pkg::BK_IDLE) && q_valid &&
                    (q_data.kind == twsm_pkg::OP_SAMPLE) && out_free;
  assign q_pop    = pop_tap || pop_smp;

  assign cur_w    = rd_wvalid_r ? rd_data_r : twsm_pkg::reset_weight(rd_idx_r);
  assign cand     = rd_vld_r && !mask_r[twsm_pkg::USED_POS[rd_idx_r]] &&
                    (!have_best_r || (cur_w > best_w_r));

  assign bin_ext  = {6'd0, bin_r};
  assign alt      = mask_r[bin_ext[5:0]] && (bin_ext[BW+5:6] == '0);
  assign last_bin = (bin_r == BW'(VECTOR_BINS - 1));

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twsm_pkg::BK_IDLE: begin
        if (pop_tap) begin
          state_nxt = twsm_pkg::BK_SCAN;
        end
      end
      twsm_pkg::BK_SCAN: begin
        if (scan_addr_r == UW'(USED - 1)) begin
          state_nxt = twsm_pkg::BK_DRAIN;
        end
      end
      twsm_pkg::BK_DRAIN: begin
        state_nxt = twsm_pkg::BK_COMMIT;
      end
      twsm_pkg::BK_COMMIT: begin
        state_nxt = (pass_r == PW'(TOP_COUNT - 1)) ? twsm_pkg::BK_IDLE : twsm_pkg::BK_SCAN;
      end
      default: begin
        state_nxt = twsm_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    scan_addr_nxt = '0;
    rd_vld_nxt    = 1'b0;
    pass_nxt      = pass_r;
    mask_nxt      = mask_r;
    have_best_nxt = have_best_r;
    best_w_nxt    = best_w_r;
    best_idx_nxt  = best_idx_r;
    wvalid_nxt    = wvalid_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    case (state_r)
      twsm_pkg::BK_IDLE: begin
        if (pop_tap) begin
          mask_nxt                   = '0;
          pass_nxt                   = '0;
          wvalid_nxt[q_data.used_idx] = 1'b1;
        end
      end
      twsm_pkg::BK_SCAN: begin
        rd_vld_nxt    = 1'b1;
        scan_addr_nxt = (scan_addr_r == UW'(USED - 1)) ? '0 : scan_addr_r + 1'b1;
      end
      twsm_pkg::BK_DRAIN: begin
        scan_addr_nxt = '0;
      end
      twsm_pkg::BK_COMMIT: begin
        if (have_best_r) begin
          mask_nxt[twsm_pkg::USED_POS[best_idx_r]] = 1'b1;
        end
        have_best_nxt = 1'b0;
        pass_nxt      = (pass_r == PW'(TOP_COUNT - 1)) ? '0 : pass_r + 1'b1;
      end
      default: begin
        scan_addr_nxt = '0;
      end
    endcase

    if (cand) begin
      have_best_nxt = 1'b1;
      best_w_nxt    = cur_w;
      best_idx_nxt  = rd_idx_r;
    end

    if (pop_smp) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.out_re         = alt ? q_data.alternate_re : q_data.primary_re;
      out_item_nxt.out_im         = alt ? q_data.alternate_im : q_data.primary_im;
      out_item_nxt.from_alternate = alt;
      out_item_nxt.bin_number     = bin_ext[5:0];
      out_item_nxt.vector_end     = last_bin;
      bin_nxt                     = last_bin ? '0 : bin_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twsm_pkg::BK_SCAN;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      pass_r      <= '0;
      mask_r      <= '0;
      have_best_r <= 1'b0;
      wvalid_r    <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= scan_addr_r;
      pass_r      <= pass_nxt;
      mask_r      <= mask_nxt;
      have_best_r <= have_best_nxt;
      wvalid_r    <= wvalid_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_w_r    <= best_w_nxt;
    best_idx_r  <= best_idx_nxt;
    out_item_r  <= out_item_nxt;
    rd_wvalid_r <= wvalid_r[scan_addr_r];
    rd_data_r   <= weight_mem[scan_addr_r];
    if (pop_tap) begin
      weight_mem[q_data.used_idx] <= q_data.weight;
    end
  end

`ifndef ASSERT_OFF
  a_mask_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(mask_r) <= TOP_COUNT)
    else $error("mask holds too many bins");

  a_mask_full_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twsm_pkg::BK_IDLE) |-> ($countones(mask_r) == TOP_COUNT))
    else $error("mask incomplete after rank walk");

  a_mask_used_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r & ~twsm_pkg::USED_MASK) == '0)
    else $error("mask marks an unused bin");

  a_bin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop_smp |=> $stable(bin_r))
    else $error("bin counter moved without a sample");
`endif

endmodule
